@@ rtl/pinhole_primary_ray_generator_top_assert.svh @@
// Assertion macros for the pinhole primary ray generator.
// Used by the top level; expects clk_i and rst_ni in the including scope.
`ifndef PINHOLE_PRIMARY_RAY_GENERATOR_TOP_ASSERT_SVH
`define PINHOLE_PRIMARY_RAY_GENERATOR_TOP_ASSERT_SVH
// Checked at every rising edge outside reset.
`define PRG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked at every rising edge, reset included.
`define PRG_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`endif

@@ rtl/prg_pkg.sv @@
// Shared widths, register indexes and reset values of the ray generator.
// No dependencies.
`default_nettype none
package prg_pkg;
  localparam int unsigned IDX_W         = 24;
  localparam int unsigned DIM_CFG_W     = 13;
  localparam int unsigned AXIS_W        = 54;
  localparam int unsigned CFG_DATA_W    = 54;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned MAX_DIM_DEF   = 4096;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned COMP_W        = FRAC_BITS_DEF + 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_RIGHT_AXIS   = 3'd2,
    CFG_UP_AXIS      = 3'd3,
    CFG_FORWARD_AXIS = 3'd4
  } cfg_reg_e;

  localparam logic [DIM_CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [DIM_CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;
endpackage
`default_nettype wire

@@ rtl/prg_req_if.sv @@
// Request channel of the ray generator: one linear pixel index per request.
// Depends on prg_pkg.
`default_nettype none
interface prg_req_if
  import prg_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] pixel_index;

  modport source (output valid, output pixel_index, input ready);
  modport sink (input valid, input pixel_index, output ready);
endinterface
`default_nettype wire

@@ rtl/prg_rsp_if.sv @@
// Response channel of the ray generator: unit direction and frame flag.
// Depends on prg_pkg.
`default_nettype none
interface prg_rsp_if
  import prg_pkg::*;
  #(parameter int unsigned CompW = COMP_W)
  ();
  logic                    valid;
  logic                    ready;
  logic signed [CompW-1:0] dir_x;
  logic signed [CompW-1:0] dir_y;
  logic signed [CompW-1:0] dir_z;
  logic                    out_of_frame;

  modport source (output valid, output dir_x, output dir_y, output dir_z,
                  output out_of_frame, input ready);
  modport sink (input valid, input dir_x, input dir_y, input dir_z,
                input out_of_frame, output ready);
endinterface
`default_nettype wire

@@ rtl/prg_div_cell.sv @@
// One restoring division cell: produces one quotient bit per request.
// No dependencies.
`default_nettype none
module prg_div_cell #(
  parameter int unsigned DenW  = 13,
  parameter int unsigned QW    = 12,
  parameter int unsigned SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [DenW-1:0]  rem_i,
  input  logic [QW-1:0]    nq_i,
  input  logic [DenW-1:0]  den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [DenW-1:0]  rem_o,
  output logic [QW-1:0]    nq_o,
  output logic [DenW-1:0]  den_o,
  output logic [SideW-1:0] side_o
);
  logic [DenW:0]    trial;
  logic [DenW:0]    diff;
  logic             take;
  logic             valid_q;
  logic [DenW-1:0]  rem_q, rem_d;
  logic [QW-1:0]    nq_q, nq_d;
  logic [DenW-1:0]  den_q;
  logic [SideW-1:0] side_q;

  // Shift the next numerator bit in and subtract the divisor when it fits.
  assign trial = {rem_i, nq_i[QW-1]};
  assign diff  = trial - {1'b0, den_i};
  assign take  = trial >= {1'b0, den_i};
  assign rem_d = take ? diff[DenW-1:0] : trial[DenW-1:0];
  assign nq_d  = QW'({nq_i, take});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Payload moves with the pipeline enable.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      nq_q   <= nq_d;
      den_q  <= den_i;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign nq_o    = nq_q;
  assign den_o   = den_q;
  assign side_o  = side_q;
endmodule
`default_nettype wire

@@ rtl/prg_div_chain.sv @@
// Row of division cells, one quotient bit per cell, QW cells long.
// Depends on prg_div_cell.
`default_nettype none
module prg_div_chain #(
  parameter int unsigned DenW  = 13,
  parameter int unsigned QW    = 12,
  parameter int unsigned SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [DenW-1:0]  rem_i,
  input  logic [QW-1:0]    nq_i,
  input  logic [DenW-1:0]  den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [QW-1:0]    quot_o,
  output logic [DenW-1:0]  rem_o,
  output logic [SideW-1:0] side_o
);
  logic             valid_w [QW+1];
  logic [DenW-1:0]  rem_w   [QW+1];
  logic [QW-1:0]    nq_w    [QW+1];
  logic [DenW-1:0]  den_w   [QW+1];
  logic [SideW-1:0] side_w  [QW+1];

  assign valid_w[0] = valid_i;
  assign rem_w[0]   = rem_i;
  assign nq_w[0]    = nq_i;
  assign den_w[0]   = den_i;
  assign side_w[0]  = side_i;

  // Each cell hands remainder and partial quotient to its neighbor.
  for (genvar i = 0; i < QW; i++) begin : g_cell
    prg_div_cell #(.DenW(DenW), .QW(QW), .SideW(SideW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .valid_i (valid_w[i]),
      .rem_i   (rem_w[i]),
      .nq_i    (nq_w[i]),
      .den_i   (den_w[i]),
      .side_i  (side_w[i]),
      .valid_o (valid_w[i+1]),
      .rem_o   (rem_w[i+1]),
      .nq_o    (nq_w[i+1]),
      .den_o   (den_w[i+1]),
      .side_o  (side_w[i+1])
    );
  end

  assign valid_o = valid_w[QW];
  assign quot_o  = nq_w[QW];
  assign rem_o   = rem_w[QW];
  assign side_o  = side_w[QW];
endmodule
`default_nettype wire

@@ rtl/prg_sqrt_cell.sv @@
// One digit-by-digit square root cell: one root bit per request.
// No dependencies.
`default_nettype none
module prg_sqrt_cell #(
  parameter int unsigned RootW = 20,
  parameter int unsigned SideW = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [RootW:0]     rem_i,
  input  logic [RootW-1:0]   root_i,
  input  logic [2*RootW-1:0] rad_i,
  input  logic [SideW-1:0]   side_i,
  output logic               valid_o,
  output logic [RootW:0]     rem_o,
  output logic [RootW-1:0]   root_o,
  output logic [2*RootW-1:0] rad_o,
  output logic [SideW-1:0]   side_o
);
  localparam int unsigned CurW = RootW + 3;

  logic [CurW-1:0]      cur;
  logic [CurW-1:0]      trial;
  logic                 take;
  logic [CurW-1:0]      diff;
  logic                 valid_q;
  logic [RootW:0]       rem_q;
  logic [RootW-1:0]     root_q;
  logic [2*RootW-1:0]   rad_q;
  logic [SideW-1:0]     side_q;

  // Bring down the next two radicand bits and try root*4+1.
  assign cur   = {rem_i, rad_i[2*RootW-1 -: 2]};
  assign trial = CurW'({root_i, 2'b01});
  assign take  = cur >= trial;
  assign diff  = cur - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= take ? diff[RootW:0] : cur[RootW:0];
      root_q <= RootW'({root_i, take});
      rad_q  <= rad_i << 2;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign rad_o   = rad_q;
  assign side_o  = side_q;
endmodule
`default_nettype wire

@@ rtl/pinhole_primary_ray_generator_top.sv @@
// Pinhole camera primary ray generator, top level.
// Depends on prg_pkg, prg_req_if, prg_rsp_if, prg_div_chain, prg_sqrt_cell
// and the assertion header.
//
// Usage: each request on req_i carries a linear pixel index. Each one gives
// exactly one response on rsp_o: the unit view direction (signed Q1.FRAC_BITS
// per component) and an out-of-frame flag; out-of-frame responses carry a
// zero direction, as does a camera setup that sums to a zero vector.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i while no
// request is in flight; unknown indexes are ignored.
// Throughput: one request per cycle while the receiver takes responses. The
// pipeline holds chains of cells for the index split, screen scaling,
// square root and normalizing division, each one bit per cell.
// A stalled receiver freezes the whole pipeline; the output register keeps
// its response and req_i.ready drops in the same cycle. Reset empties the
// pipeline and restores the default camera (640x480, axes x, y, z).
`default_nettype none
`include "pinhole_primary_ray_generator_top_assert.svh"
module pinhole_primary_ray_generator_top
  import prg_pkg::*;
#(
  parameter int unsigned MAX_DIM   = MAX_DIM_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  prg_req_if.sink               req_i,
  prg_rsp_if.source             rsp_o
);
  localparam int unsigned F     = FRAC_BITS;
  localparam int unsigned CW    = F + 2;
  localparam int unsigned DW    = $clog2(MAX_DIM + 1);
  localparam int unsigned QR    = $clog2(MAX_DIM);
  localparam int unsigned PW    = 2 * DW;
  localparam int unsigned CMPW  = IDX_W + PW;
  localparam int unsigned SHR   = (F > 26) ? F - 26 : 0;
  localparam int unsigned EW    = F + 4 - SHR;
  localparam int unsigned LW    = 2 * EW;
  localparam int unsigned DSW   = 2 * CW + 2;
  localparam int unsigned QS    = F + 1;
  localparam int unsigned NW    = EW + F + 2;
  localparam int unsigned DDW   = EW + 1;
  localparam int unsigned AXW   = (3 * CW > AXIS_W) ? 3 * CW : AXIS_W;
  localparam int unsigned SQSW  = 3 * EW + 1;
  localparam logic signed [CW-1:0] ONE_S = CW'(1) << F;

  // ---------------------------------------------------------------- config
  logic [DIM_CFG_W-1:0] frame_width_q, frame_height_q;
  logic [AXIS_W-1:0]    right_axis_q, up_axis_q, forward_axis_q;
  logic [DW-1:0]        w_c, h_c;
  logic [PW-1:0]        area;

  // Register writes; indexes beyond the list fall through.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
      right_axis_q   <= AXIS_W'(AXW'(1) << F);
      up_axis_q      <= AXIS_W'(AXW'(1) << (F + CW));
      forward_axis_q <= AXIS_W'(AXW'(1) << (F + 2 * CW));
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[DIM_CFG_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[DIM_CFG_W-1:0];
        CFG_RIGHT_AXIS:   right_axis_q   <= cfg_data_i[AXIS_W-1:0];
        CFG_UP_AXIS:      up_axis_q      <= cfg_data_i[AXIS_W-1:0];
        CFG_FORWARD_AXIS: forward_axis_q <= cfg_data_i[AXIS_W-1:0];
        default: ;
      endcase
    end
  end

  // Dimensions saturate at MAX_DIM.
  assign w_c = (32'(frame_width_q) > MAX_DIM) ? DW'(MAX_DIM) : DW'(frame_width_q);
  assign h_c = (32'(frame_height_q) > MAX_DIM) ? DW'(MAX_DIM) : DW'(frame_height_q);

  // Frame area straight from the registers, so a request right after a write sees it.
  assign area = PW'(w_c) * PW'(h_c);

  // Camera axis components.
  logic [AXW-1:0]         right_ext, up_ext, fwd_ext;
  logic signed [CW-1:0]   right_c [3];
  logic signed [CW-1:0]   up_c    [3];
  logic signed [CW-1:0]   fwd_c   [3];

  assign right_ext = AXW'(right_axis_q);
  assign up_ext    = AXW'(up_axis_q);
  assign fwd_ext   = AXW'(forward_axis_q);

  for (genvar k = 0; k < 3; k++) begin : g_comp
    assign right_c[k] = $signed(right_ext[k*CW +: CW]);
    assign up_c[k]    = $signed(up_ext[k*CW +: CW]);
    assign fwd_c[k]   = $signed(fwd_ext[k*CW +: CW]);
  end

  // ------------------------------------------------------ pipeline control
  logic en;
  logic out_valid_q;

  assign en          = !out_valid_q || rsp_o.ready;
  assign req_i.ready = en;

  // --------------------------------------------------- index to row/column
  logic          in_oof;
  logic          iv, ioof;
  logic [QR-1:0] irow;
  logic [DW-1:0] icol;

  assign in_oof = CMPW'(req_i.pixel_index) >= CMPW'(area);

  prg_div_chain #(.DenW(DW), .QW(QR), .SideW(1)) u_idx_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (req_i.valid),
    .rem_i   (DW'(req_i.pixel_index >> QR)),
    .nq_i    (req_i.pixel_index[QR-1:0]),
    .den_i   (w_c),
    .side_i  (in_oof),
    .valid_o (iv),
    .quot_o  (irow),
    .rem_o   (icol),
    .side_o  (ioof)
  );

  // --------------------------------------------- screen coordinate scaling
  // sx + 2^F = col * 2^(F+1) / w, likewise for sy with row and h.
  logic          xv, xoof;
  logic [QS-1:0] qx, qy;

  prg_div_chain #(.DenW(DW), .QW(QS), .SideW(1)) u_sx_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (iv),
    .rem_i   (icol),
    .nq_i    ('0),
    .den_i   (w_c),
    .side_i  (ioof),
    .valid_o (xv),
    .quot_o  (qx),
    .rem_o   (),
    .side_o  (xoof)
  );

  prg_div_chain #(.DenW(DW), .QW(QS), .SideW(1)) u_sy_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (iv),
    .rem_i   (DW'(irow)),
    .nq_i    ('0),
    .den_i   (h_c),
    .side_i  (1'b0),
    .valid_o (),
    .quot_o  (qy),
    .rem_o   (),
    .side_o  ()
  );

  // ------------------------------------------------------ axis products
  logic signed [CW-1:0]   sx, sy;
  logic                   m_valid_q, m_oof_q;
  logic signed [2*CW-1:0] pr_q [3];
  logic signed [2*CW-1:0] pu_q [3];
  logic signed [CW-1:0]   pf_q [3];

  assign sx = $signed({1'b0, qx}) - ONE_S;
  assign sy = $signed({1'b0, qy}) - ONE_S;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= xv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_oof_q <= xoof;
      for (int k = 0; k < 3; k++) begin
        pr_q[k] <= sx * right_c[k];
        pu_q[k] <= sy * up_c[k];
        pf_q[k] <= fwd_c[k];
      end
    end
  end

  // ------------------------------------------------ sum and round to Q.F
  logic signed [DSW-1:0] dsum [3];
  logic signed [DSW-1:0] dq   [3];
  logic signed [DSW-1:0] dadj [3];
  logic                  a_valid_q, a_oof_q;
  logic signed [EW-1:0]  ea_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dsum[k] = DSW'(pr_q[k]) + DSW'(pu_q[k]) + (DSW'(pf_q[k]) <<< F)
              + (DSW'(1) << (F - 1));
      dq[k]   = dsum[k] >>> F;
      // Truncating scale-down keeps the sum of squares in range.
      dadj[k] = dq[k] + (dq[k][DSW-1] ? DSW'((64'd1 << SHR) - 64'd1) : DSW'(0));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= m_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_oof_q <= m_oof_q;
      for (int k = 0; k < 3; k++) begin
        ea_q[k] <= EW'(dadj[k] >>> SHR);
      end
    end
  end

  // ------------------------------------------------------------ squares
  logic                 q_valid_q, q_oof_q;
  logic [LW-1:0]        sq_q [3];
  logic signed [EW-1:0] eq_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_valid_q <= 1'b0;
    end else if (en) begin
      q_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      q_oof_q <= a_oof_q;
      for (int k = 0; k < 3; k++) begin
        sq_q[k] <= LW'(ea_q[k]) * LW'(ea_q[k]);
        eq_q[k] <= ea_q[k];
      end
    end
  end

  // -------------------------------------------------- squared length
  logic                 l_valid_q, l_oof_q;
  logic [LW-1:0]        l2_q;
  logic signed [EW-1:0] el_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l_valid_q <= 1'b0;
    end else if (en) begin
      l_valid_q <= q_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      l_oof_q <= q_oof_q;
      l2_q    <= sq_q[0] + sq_q[1] + sq_q[2];
      el_q    <= eq_q;
    end
  end

  // ------------------------------------------------------- square root
  logic            sq_valid_w [EW+1];
  logic [EW:0]     sq_rem_w   [EW+1];
  logic [EW-1:0]   sq_root_w  [EW+1];
  logic [LW-1:0]   sq_rad_w   [EW+1];
  logic [SQSW-1:0] sq_side_w  [EW+1];

  assign sq_valid_w[0] = l_valid_q;
  assign sq_rem_w[0]   = '0;
  assign sq_root_w[0]  = '0;
  assign sq_rad_w[0]   = l2_q;
  assign sq_side_w[0]  = {l_oof_q, el_q[2], el_q[1], el_q[0]};

  for (genvar i = 0; i < EW; i++) begin : g_sqrt
    prg_sqrt_cell #(.RootW(EW), .SideW(SQSW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_valid_w[i]),
      .rem_i   (sq_rem_w[i]),
      .root_i  (sq_root_w[i]),
      .rad_i   (sq_rad_w[i]),
      .side_i  (sq_side_w[i]),
      .valid_o (sq_valid_w[i+1]),
      .rem_o   (sq_rem_w[i+1]),
      .root_o  (sq_root_w[i+1]),
      .rad_o   (sq_rad_w[i+1]),
      .side_o  (sq_side_w[i+1])
    );
  end

  // ------------------------------------------------ normalizing division
  // dir = round(|e| * 2^F / S) = floor((2*|e|*2^F + S) / (2*S)).
  logic [EW-1:0]   s_len;
  logic            s_oof, s_zero;
  logic [EW-1:0]   s_e   [3];
  logic [EW-1:0]   s_mag [3];
  logic [NW-1:0]   s_num [3];
  logic [DDW-1:0]  s_den;
  logic [QS-1:0]   nq    [3];
  logic            n_valid;
  logic [4:0]      n_side;

  assign s_len  = sq_root_w[EW];
  assign s_oof  = sq_side_w[EW][SQSW-1];
  assign s_zero = (s_len == '0);
  assign s_den  = {s_len, 1'b0};

  for (genvar k = 0; k < 3; k++) begin : g_norm
    assign s_e[k]   = sq_side_w[EW][k*EW +: EW];
    assign s_mag[k] = s_e[k][EW-1] ? EW'(-s_e[k]) : s_e[k];
    assign s_num[k] = (NW'(s_mag[k]) << (F + 1)) + NW'(s_len);
  end

  prg_div_chain #(.DenW(DDW), .QW(QS), .SideW(5)) u_norm_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid_w[EW]),
    .rem_i   (DDW'(s_num[0] >> QS)),
    .nq_i    (s_num[0][QS-1:0]),
    .den_i   (s_den),
    .side_i  ({s_oof, s_zero, s_e[2][EW-1], s_e[1][EW-1], s_e[0][EW-1]}),
    .valid_o (n_valid),
    .quot_o  (nq[0]),
    .rem_o   (),
    .side_o  (n_side)
  );

  prg_div_chain #(.DenW(DDW), .QW(QS), .SideW(1)) u_norm_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid_w[EW]),
    .rem_i   (DDW'(s_num[1] >> QS)),
    .nq_i    (s_num[1][QS-1:0]),
    .den_i   (s_den),
    .side_i  (1'b0),
    .valid_o (),
    .quot_o  (nq[1]),
    .rem_o   (),
    .side_o  ()
  );

  prg_div_chain #(.DenW(DDW), .QW(QS), .SideW(1)) u_norm_z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid_w[EW]),
    .rem_i   (DDW'(s_num[2] >> QS)),
    .nq_i    (s_num[2][QS-1:0]),
    .den_i   (s_den),
    .side_i  (1'b0),
    .valid_o (),
    .quot_o  (nq[2]),
    .rem_o   (),
    .side_o  ()
  );

  // ---------------------------------------------------- output register
  logic [QS-1:0]        nsat [3];
  logic signed [CW-1:0] dir_d [3];
  logic signed [CW-1:0] dir_q [3];
  logic                 oof_q;

  // Saturate, restore the sign, and force zero for the special cases.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nsat[k] = (nq[k] > QS'(ONE_S)) ? QS'(ONE_S) : nq[k];
      if (n_side[4] || n_side[3]) begin
        dir_d[k] = '0;
      end else if (n_side[k]) begin
        dir_d[k] = -$signed(CW'(nsat[k]));
      end else begin
        dir_d[k] = $signed(CW'(nsat[k]));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= n_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dir_q <= dir_d;
      oof_q <= n_side[4];
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.dir_x        = dir_q[0];
  assign rsp_o.dir_y        = dir_q[1];
  assign rsp_o.dir_z        = dir_q[2];
  assign rsp_o.out_of_frame = oof_q;

  // ------------------------------------------------------------ checks
  logic rsp_dir_zero, rsp_dir_in_range;

  // Summaries of the response payload for the checks below.
  assign rsp_dir_zero     = (rsp_o.dir_x == '0) && (rsp_o.dir_y == '0) && (rsp_o.dir_z == '0);
  assign rsp_dir_in_range = (rsp_o.dir_x <= ONE_S) && (rsp_o.dir_x >= -ONE_S)
                         && (rsp_o.dir_y <= ONE_S) && (rsp_o.dir_y >= -ONE_S)
                         && (rsp_o.dir_z <= ONE_S) && (rsp_o.dir_z >= -ONE_S);

  `PRG_ASSERT(a_oof_zero_dir, rsp_o.valid && rsp_o.out_of_frame |-> rsp_dir_zero, "out-of-frame response with nonzero direction")
  `PRG_ASSERT(a_dir_range, rsp_o.valid |-> rsp_dir_in_range, "direction component beyond unit range")
  `PRG_ASSERT(a_stall_blocks_req, rsp_o.valid && !rsp_o.ready |-> !req_i.ready, "request taken while response is stalled")
  `PRG_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !rsp_o.valid, "response valid during reset")
endmodule
`default_nettype wire

@@ verif/prg_ray_checker.sv @@
// Checker for the pinhole primary ray generator: watches both channels,
// predicts each ray direction and compares it with the response.
// Depends on prg_pkg, prg_req_if and prg_rsp_if.
`timescale 1ns / 100ps
module prg_ray_checker
  import prg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  prg_req_if                    req,
  prg_rsp_if                    rsp,
  output int                    fail_count_o,
  output int                    pending_o
);

  typedef struct packed {
    logic signed [COMP_W-1:0] dx;
    logic signed [COMP_W-1:0] dy;
    logic signed [COMP_W-1:0] dz;
    logic                     oof;
  } ray_t;

  localparam longint ONE = 64'sd1 <<< FRAC_BITS_DEF;

  logic [DIM_CFG_W-1:0] width_q, height_q;
  logic [AXIS_W-1:0]    right_q, up_q, fwd_q;
  ray_t                 ray_q[$];

  assign pending_o = ray_q.size();

  function automatic longint axis_comp(logic [AXIS_W-1:0] axis, int k);
    logic signed [COMP_W-1:0] c;
    c = axis[k*COMP_W +: COMP_W];
    return longint'(c);
  endfunction

  function automatic longint div_floor(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Expected ray direction for one pixel index under the current camera.
  function automatic ray_t ray_for_pixel(logic [IDX_W-1:0] pix);
    ray_t            r;
    longint          w, h, col, row, sx, sy, d, e[3];
    longint unsigned l2, s, mag, q;
    r = '0;
    w = (width_q > MAX_DIM_DEF) ? MAX_DIM_DEF : width_q;
    h = (height_q > MAX_DIM_DEF) ? MAX_DIM_DEF : height_q;
    if (longint'(pix) >= w * h) begin
      r.oof = 1'b1;
      return r;
    end
    col = longint'(pix) % w;
    row = longint'(pix) / w;
    sx = div_floor((2 * col - w) * ONE, w);
    sy = div_floor((2 * row - h) * ONE, h);
    l2 = 0;
    for (int k = 0; k < 3; k++) begin
      d = sx * axis_comp(right_q, k) + sy * axis_comp(up_q, k)
        + axis_comp(fwd_q, k) * ONE;
      e[k] = div_floor(d + ONE / 2, ONE);
      l2 += longint'(e[k] * e[k]);
    end
    s = root_floor(l2);
    if (s == 0) return r;
    for (int k = 0; k < 3; k++) begin
      mag = longint'(e[k] < 0 ? -e[k] : e[k]) << FRAC_BITS_DEF;
      q = (2 * mag + s) / (2 * s);
      if (q > ONE) q = ONE;
      d = e[k] < 0 ? -longint'(q) : longint'(q);
      case (k)
        0: r.dx = d[COMP_W-1:0];
        1: r.dy = d[COMP_W-1:0];
        default: r.dz = d[COMP_W-1:0];
      endcase
    end
    return r;
  endfunction

  // Track configuration, queue predictions and compare responses.
  always @(posedge clk_i or negedge rst_ni) begin
    ray_t exp_ray;
    if (!rst_ni) begin
      width_q  <= FRAME_WIDTH_RST;
      height_q <= FRAME_HEIGHT_RST;
      right_q  <= AXIS_W'(1) << FRAC_BITS_DEF;
      up_q     <= AXIS_W'(1) << (FRAC_BITS_DEF + COMP_W);
      fwd_q    <= AXIS_W'(1) << (FRAC_BITS_DEF + 2 * COMP_W);
      ray_q.delete();
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FRAME_WIDTH:  width_q  <= cfg_data_i[DIM_CFG_W-1:0];
          CFG_FRAME_HEIGHT: height_q <= cfg_data_i[DIM_CFG_W-1:0];
          CFG_RIGHT_AXIS:   right_q  <= cfg_data_i;
          CFG_UP_AXIS:      up_q     <= cfg_data_i;
          CFG_FORWARD_AXIS: fwd_q    <= cfg_data_i;
          default: ;
        endcase
      end
      if (req.valid && req.ready) ray_q.push_back(ray_for_pixel(req.pixel_index));
      if (rsp.valid && rsp.ready) begin
        if (ray_q.size() == 0) begin
          $error("response with no request outstanding");
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_ray = ray_q.pop_front();
          if (rsp.dir_x !== exp_ray.dx || rsp.dir_y !== exp_ray.dy ||
              rsp.dir_z !== exp_ray.dz || rsp.out_of_frame !== exp_ray.oof)
            fail_count_o <= fail_count_o + 1;
          if (rsp.dir_x !== exp_ray.dx)
            $error("dir_x expected %0d got %0d", exp_ray.dx, rsp.dir_x);
          if (rsp.dir_y !== exp_ray.dy)
            $error("dir_y expected %0d got %0d", exp_ray.dy, rsp.dir_y);
          if (rsp.dir_z !== exp_ray.dz)
            $error("dir_z expected %0d got %0d", exp_ray.dz, rsp.dir_z);
          if (rsp.out_of_frame !== exp_ray.oof)
            $error("out_of_frame expected %0d got %0d", exp_ray.oof, rsp.out_of_frame);
        end
      end
    end
  end

endmodule

@@ verif/tb_pinhole_primary_ray_generator_top.sv @@
// Testbench top for the pinhole primary ray generator: drives pixel indexes
// and camera setups under varied idling and gives the verdict.
// Depends on prg_pkg, the channel interfaces, the block and prg_ray_checker.
`timescale 1ns / 100ps
module tb_pinhole_primary_ray_generator_top;
  import prg_pkg::*;

  localparam int LATENCY   = 71;
  localparam int MAX_CYCLE = 2000000;

  logic                  clk_i, rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  int                    fail_count, pending, cycle_count;
  int                    send_idle_pct, recv_stall_pct;
  bit                    hold_off;

  prg_req_if req_ch ();
  prg_rsp_if rsp_ch ();

  pinhole_primary_ray_generator_top dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .req_i(req_ch.sink), .rsp_o(rsp_ch.source)
  );

  prg_ray_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .req(req_ch), .rsp(rsp_ch),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog on total run length.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > MAX_CYCLE) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Response side: random stalls, plus a long hold-off when requested.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // One register write, after which the write enable drops before the task returns.
  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait for the pipeline to drain before touching the camera.
  task automatic drain_rays();
    req_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  // Valid stays high between back-to-back requests; it drops only for idling or a drain.
  task automatic send_pixel(logic [IDX_W-1:0] pix);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid       <= 1'b1;
    req_ch.pixel_index <= pix;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  function automatic logic [COMP_W-1:0] rand_comp();
    case ($urandom_range(3))
      0: return COMP_W'(1 << 16);
      1: return -COMP_W'(1 << 16);
      2: return COMP_W'($urandom_range(0, 2 ** COMP_W - 1));
      default: return COMP_W'($urandom_range(0, 4096)) - COMP_W'(2048);
    endcase
  endfunction

  function automatic logic [AXIS_W-1:0] rand_axis();
    return {rand_comp(), rand_comp(), rand_comp()};
  endfunction

  // Random pixel: mostly in frame, some just past or far beyond.
  function automatic logic [IDX_W-1:0] rand_pixel(int w, int h);
    int area;
    area = (w > 4096 ? 4096 : w) * (h > 4096 ? 4096 : h);
    case ($urandom_range(9))
      0: return IDX_W'($urandom);
      1: return IDX_W'(area + $urandom_range(3));
      default: return area == 0 ? IDX_W'($urandom) : IDX_W'($urandom_range(area - 1));
    endcase
  endfunction

  initial begin
    int w, h;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_FRAME_WIDTH;
    cfg_data_i = '0;
    req_ch.valid = 1'b0;
    req_ch.pixel_index = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: default camera, frame corners, edges and out-of-frame indexes.
    send_pixel(0);
    send_pixel(639);
    send_pixel(640);
    send_pixel(320 + 240 * 640);
    send_pixel(307199);
    send_pixel(307200);
    send_pixel(24'hFFFFFF);
    send_pixel(24'hAAAAAA);
    send_pixel(24'h555555);
    drain_rays();

    // Zero forward axis: the image center gives a zero-length direction.
    write_reg(CFG_FORWARD_AXIS, '0);
    send_pixel(320 + 240 * 640);
    send_pixel(0);
    drain_rays();
    // Zero width: every index is out of frame; oversize dims saturate.
    write_reg(CFG_FRAME_WIDTH, '0);
    send_pixel(0);
    drain_rays();
    write_reg(CFG_FRAME_WIDTH, 13'h1FFF);
    write_reg(CFG_FRAME_HEIGHT, 13'h1FFF);
    write_reg(CFG_FORWARD_AXIS, {COMP_W'(1 << 16), {(2 * COMP_W){1'b0}}});
    send_pixel(0);
    send_pixel(24'hFFFFFF);
    send_pixel(4096 * 2048 + 2048);
    drain_rays();
    write_reg(CFG_FRAME_WIDTH, 13'd1);
    write_reg(CFG_FRAME_HEIGHT, 13'd1);
    write_reg(CFG_RIGHT_AXIS, '1);
    write_reg(CFG_UP_AXIS, {3{COMP_W'(1 << (COMP_W - 1))}});
    send_pixel(0);
    send_pixel(1);
    drain_rays();

    // Random phases: each with its own camera and idling pattern.
    for (int phase = 0; phase < 14; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      case (phase % 5)
        0: begin w = 1; h = $urandom_range(1, 64); end
        1: begin w = 4096; h = 4096; end
        2: begin w = $urandom_range(1, 8191); h = $urandom_range(1, 8191); end
        3: begin w = $urandom_range(1, 40); h = $urandom_range(1, 40); end
        default: begin w = $urandom_range(0, 2); h = $urandom_range(0, 4096); end
      endcase
      write_reg(CFG_FRAME_WIDTH, DIM_CFG_W'(w));
      write_reg(CFG_FRAME_HEIGHT, DIM_CFG_W'(h));
      write_reg(CFG_RIGHT_AXIS, rand_axis());
      write_reg(CFG_UP_AXIS, rand_axis());
      write_reg(CFG_FORWARD_AXIS, rand_axis());
      // Hold the receiver off so the pipeline backs up into the request side.
      if (phase == 4)
        fork
          begin
            hold_off = 1'b1;
            repeat (300) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      repeat (100) send_pixel(rand_pixel(w, h));
      drain_rays();
    end

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/prg_pkg.sv
rtl/prg_req_if.sv
rtl/prg_rsp_if.sv
rtl/prg_div_cell.sv
rtl/prg_div_chain.sv
rtl/prg_sqrt_cell.sv
rtl/pinhole_primary_ray_generator_top.sv
verif/prg_ray_checker.sv
verif/tb_pinhole_primary_ray_generator_top.sv
